[hdl/fpa_pkg.sv]
package fpa_pkg;

	localparam int FIELD_W       = 32;
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [3:0] {
		F_ADD     = 4'd0,
		F_SUB     = 4'd1,
		F_MUL     = 4'd2,
		F_DIV     = 4'd3,
		F_LT      = 4'd4,
		F_GT      = 4'd5,
		F_LE      = 4'd6,
		F_GE      = 4'd7,
		F_EQ      = 4'd8,
		F_NE      = 4'd9,
		F_MIN     = 4'd10,
		F_MAX     = 4'd11,
		F_INC     = 4'd12,
		F_DEC     = 4'd13,
		F_TOINT   = 4'd14,
		F_FROMINT = 4'd15
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef struct packed {
		func_t                      func;
		logic signed [FIELD_W-1:0]  operand_a;
		logic signed [FIELD_W-1:0]  operand_b;
	} op_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0]  result_word;
		logic                       compare_true;
		status_t                    status;
	} res_t;

endpackage

[hdl/fixed_point_alu.sv]
// Signed fixed-point ALU with FRAC_BITS fraction bits on a working width of
// min(WORD_BITS, 32) bits. It accepts one item per cycle while the result side
// does not stall, and each result leaves through the output register after
// the divider, which resolves one quotient bit per pipeline stage; every other
// operation travels alongside it in a delay line. Multiply and divide round
// half away from zero, overflow saturates with status 1, and divide by zero
// gives status 2. A stall on the result side freezes the whole pipeline.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int E    = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
	localparam int F    = FRAC_BITS;
	localparam int NB   = E + F;
	localparam int SW   = E + F + 2;
	localparam int QW   = (2 * E + 1 > NB + 1) ? 2 * E + 1 : NB + 1;
	localparam int HALF = 1 << (F - 1);
	localparam logic [E-1:0] MAXV = {1'b0, {(E-1){1'b1}}};
	localparam logic [E-1:0] MINV = {1'b1, {(E-1){1'b0}}};

	typedef struct packed {
		func_t        func;
		logic [E-1:0] rword;
		logic         cmp;
		status_t      stat;
		logic         neg;
		logic         bz;
	} line_t;

	function automatic logic [E:0] sat_w(input logic signed [SW-1:0] v);
		logic ov;
		ov = !((&v[SW-1:E-1]) || !(|v[SW-1:E-1]));
		return {ov, ov ? (v[SW-1] ? MINV : MAXV) : v[E-1:0]};
	endfunction

	// Applies the sign to a magnitude and saturates it to the working range.
	function automatic logic [E:0] mag_sat(input logic [QW-1:0] q, input logic neg);
		logic [QW-1:0] hw;
		logic          ov;
		logic [E-1:0]  val;
		hw = q >> (E - 1);
		if (neg) begin
			ov  = (hw > QW'(1)) || ((hw == QW'(1)) && (q[E-2:0] != '0));
			val = ov ? MINV : (~q[E-1:0] + 1'b1);
		end else begin
			ov  = hw != '0;
			val = ov ? MAXV : q[E-1:0];
		end
		return {ov, val};
	endfunction

	logic en;
	logic res_valid_q;
	res_t res_q;

	assign en       = !res_valid_q || !res_stall;
	assign op_stall = !en;

	// First stage: everything but multiply and the divide quotient.
	logic signed [E-1:0]  a, b;
	logic signed [SW-1:0] xa, xb;
	logic [E:0]           sv;
	logic [E-1:0]         amag, bmag;
	line_t                l0;

	always_comb begin
		a    = $signed(op.operand_a[E-1:0]);
		b    = $signed(op.operand_b[E-1:0]);
		xa   = SW'(a);
		xb   = SW'(b);
		amag = a[E-1] ? E'(-a) : E'(a);
		bmag = b[E-1] ? E'(-b) : E'(b);
		sv   = '0;
		l0       = '0;
		l0.func  = op.func;
		l0.stat  = ST_OK;
		l0.neg   = a[E-1] ^ b[E-1];
		l0.bz    = b == '0;
		case (op.func)
			F_ADD: begin
				sv = sat_w(xa + xb);
				l0.rword = sv[E-1:0];
				l0.stat  = sv[E] ? ST_SAT : ST_OK;
			end
			F_SUB: begin
				sv = sat_w(xa - xb);
				l0.rword = sv[E-1:0];
				l0.stat  = sv[E] ? ST_SAT : ST_OK;
			end
			F_INC: begin
				sv = sat_w(xa + SW'(1));
				l0.rword = sv[E-1:0];
				l0.stat  = sv[E] ? ST_SAT : ST_OK;
			end
			F_DEC: begin
				sv = sat_w(xa - SW'(1));
				l0.rword = sv[E-1:0];
				l0.stat  = sv[E] ? ST_SAT : ST_OK;
			end
			F_FROMINT: begin
				sv = sat_w(xa <<< F);
				l0.rword = sv[E-1:0];
				l0.stat  = sv[E] ? ST_SAT : ST_OK;
			end
			F_DIV: begin
				if (b == '0) begin
					l0.stat  = ST_DIVZ;
					l0.rword = a[E-1] ? MINV : ((a == '0) ? '0 : MAXV);
				end
			end
			F_LT:    l0.cmp = a < b;
			F_GT:    l0.cmp = a > b;
			F_LE:    l0.cmp = a <= b;
			F_GE:    l0.cmp = a >= b;
			F_EQ:    l0.cmp = a == b;
			F_NE:    l0.cmp = a != b;
			F_MIN:   l0.rword = (a < b) ? a : b;
			F_MAX:   l0.rword = (a > b) ? a : b;
			F_TOINT: l0.rword = a >>> F;
			default: l0.rword = '0;
		endcase
	end

	line_t               dly_s [NB];
	logic                vld_s [NB];
	logic signed [E-1:0] a_s1, b_s1;
	logic signed [2*E-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NB; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= op_valid;
			for (int k = 1; k < NB; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Multiply rounding and saturation, applied as the item enters the third stage.
	logic [2*E-1:0] pmag;
	logic [QW-1:0]  mq;
	logic [E:0]     mv;
	line_t          l2;

	always_comb begin
		pmag = prod_s2[2*E-1] ? (2*E)'(-prod_s2) : (2*E)'(prod_s2);
		mq   = (QW'(pmag) + QW'(HALF)) >> F;
		mv   = mag_sat(mq, prod_s2[2*E-1]);
		l2   = dly_s[1];
		if (dly_s[1].func == F_MUL) begin
			l2.rword = mv[E-1:0];
			l2.stat  = mv[E] ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= l0;
			a_s1     <= a;
			b_s1     <= b;
			prod_s2  <= a_s1 * b_s1;
			dly_s[1] <= dly_s[0];
			dly_s[2] <= l2;
			for (int k = 3; k < NB; k++) dly_s[k] <= dly_s[k-1];
		end
	end

	logic [NB-1:0] quo;
	logic          rnd;

	fpa_div #(
		.NB(NB),
		.DB(E)
	) u_div (
		.clk    (clk),
		.en     (en),
		.num    ({amag, {F{1'b0}}}),
		.den    (bmag),
		.quo    (quo),
		.rnd    (rnd)
	);

	// Final stage: divide quotient, then the output register.
	logic [QW-1:0] dq;
	logic [E:0]    dv;
	line_t         lf;

	always_comb begin
		dq = QW'(quo) + QW'(rnd);
		dv = mag_sat(dq, dly_s[NB-1].neg);
		lf = dly_s[NB-1];
		if (dly_s[NB-1].func == F_DIV && !dly_s[NB-1].bz) begin
			lf.rword = dv[E-1:0];
			lf.stat  = dv[E] ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= vld_s[NB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.result_word  <= FIELD_W'($signed(lf.rword));
			res_q.compare_true <= lf.cmp;
			res_q.status       <= lf.stat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.compare_true |-> res.status == ST_OK && res.result_word == '0)
		else $error("compare result carries a word or status");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[NB-1]))
		else $error("pipeline moved during a stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[NB-1] |=> res_valid)
		else $error("item lost at the output register");

endmodule

[hdl/fpa_div.sv]
module fpa_div import fpa_pkg::*; #(
	parameter int NB = 40,
	parameter int DB = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	output logic [NB-1:0] quo,
	output logic          rnd
);

	// One quotient bit per stage, restoring long division, numerator MSB first.
	logic [DB:0]   rem_s [NB];
	logic [NB-1:0] quo_s [NB];
	logic [NB-1:0] num_s [NB];
	logic [DB-1:0] den_s [NB];

	for (genvar i = 0; i < NB; i++) begin : g_stage
		logic [DB:0]   p_rem;
		logic [NB-1:0] p_quo;
		logic [NB-1:0] p_num;
		logic [DB-1:0] p_den;
		logic [DB:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign p_rem = '0;
			assign p_quo = '0;
			assign p_num = num;
			assign p_den = den;
		end else begin : g_next
			assign p_rem = rem_s[i-1];
			assign p_quo = quo_s[i-1];
			assign p_num = num_s[i-1];
			assign p_den = den_s[i-1];
		end

		assign trial = {p_rem[DB-1:0], p_num[NB-1]};
		assign ge    = trial >= {1'b0, p_den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? trial - {1'b0, p_den} : trial;
				quo_s[i] <= {p_quo[NB-2:0], ge};
				num_s[i] <= {p_num[NB-2:0], 1'b0};
				den_s[i] <= p_den;
			end
		end
	end

	assign quo = quo_s[NB-1];
	// Round half away from zero: bump when twice the remainder reaches the divisor.
	assign rnd = {rem_s[NB-1], 1'b0} >= {2'b00, den_s[NB-1]};

endmodule
